### hdl/ppwi_pkg.sv
// Package for the pilot point weighted interpolation block.
// Holds the fixed-point constants, the power-of-two root table and the codes.
// No dependencies.
`default_nettype none
package ppwi_pkg;

	// Input item function codes.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_ROW  = 1'b1;

	// Configuration register indexes (bit 2 of the byte address).
	localparam logic [0:0] REG_LOG_MODE  = 1'b0;
	localparam logic [0:0] REG_LOG_FLOOR = 1'b1;

	localparam logic [30:0] FLOOR_RESET = 31'd66;

	// log10(2) in Q0.32 and log2(10) in Q4.28.
	localparam logic [31:0] LOG10_2_Q32 = 32'd1292913987;
	localparam logic [31:0] LOG2_10_Q28 = 32'd891723283;

	typedef logic [31:0] exp_tab_t [0:16];

	// Integer square root, evaluated at elaboration only.
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x = x_in;
		res = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Q1.30 factors 2^(2^-k): each entry is the square root of the previous one.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		logic [63:0] prev;
		prev = 64'd1 << 31;
		t[0] = prev[31:0];
		for (int k = 1; k <= 16; k++) begin
			prev = isqrt64(prev << 30);
			t[k] = prev[31:0];
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

### hdl/ppwi_if.sv
// Stream interfaces of the pilot point weighted interpolation block.
// One interface for input items and one for result items; no dependencies.
`default_nettype none
interface ppwi_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [10:0]        point_id;
	logic signed [31:0] point_value;
	logic signed [31:0] weight;
	logic               last_in_row;

	modport source(output valid, func, point_id, point_value, weight, last_in_row,
		input ready);
	modport sink(input valid, func, point_id, point_value, weight, last_in_row,
		output ready);
endinterface

interface ppwi_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] row_value;
	logic               row_error;

	modport source(output valid, row_value, row_error, input ready);
	modport sink(input valid, row_value, row_error, output ready);
endinterface
`default_nettype wire

### hdl/ppwi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module ppwi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                                      clk,
	input  wire                                      we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                          wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hdl/ppwi_log10.sv
// Iterative log10 unit for positive Q16.16 values, result in Q16.16.
// Uses ppwi_pkg; normalizes one bit a cycle, then one squaring a cycle.
`default_nettype none
module ppwi_log10 (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire [30:0]        v,
	output logic              done,
	output logic signed [31:0] result
);
	import ppwi_pkg::*;

	typedef enum logic [3:0] {
		L_IDLE = 4'b0001,
		L_NORM = 4'b0010,
		L_SQR  = 4'b0100,
		L_FIN  = 4'b1000
	} lstate_t;

	lstate_t      st_q;
	logic [30:0]  m_q;
	logic [4:0]   n_q;
	logic [15:0]  frac_q;
	logic [3:0]   cnt_q;
	logic [63:0]  sq;
	logic [33:0]  sh;
	logic signed [21:0] l2;
	logic signed [53:0] lp;

	// Square of the mantissa and the scaled log2 value.
	always_comb begin
		sq = 64'({33'd0, m_q} * {33'd0, m_q});
		sh = sq[63:30];
		l2 = {6'(n_q) - 6'd16, frac_q};
		lp = 54'(l2 * $signed({1'b0, LOG10_2_Q32})) + 54'sd2147483648;
	end

	// Sequencer: normalize, square sixteen times, scale by log10(2).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				L_IDLE: begin
					if (start) begin
						st_q <= L_NORM;
					end
				end
				L_NORM: begin
					if (n_q == 5'd0 || m_q[30]) begin
						st_q <= L_SQR;
					end
				end
				L_SQR: begin
					if (cnt_q == 4'd15) begin
						st_q <= L_FIN;
					end
				end
				L_FIN: begin
					st_q <= L_IDLE;
					done <= 1'b1;
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (st_q)
			L_IDLE: begin
				m_q    <= (v == 31'd0) ? 31'd1 : v;
				n_q    <= 5'd30;
				cnt_q  <= 4'd0;
				frac_q <= 16'd0;
			end
			L_NORM: begin
				if (n_q != 5'd0 && !m_q[30]) begin
					m_q <= {m_q[29:0], 1'b0};
					n_q <= n_q - 5'd1;
				end
			end
			L_SQR: begin
				cnt_q <= cnt_q + 4'd1;
				if (sh[31]) begin
					frac_q <= {frac_q[14:0], 1'b1};
					m_q    <= sh[31:1];
				end else begin
					frac_q <= {frac_q[14:0], 1'b0};
					m_q    <= sh[30:0];
				end
			end
			L_FIN: begin
				result <= 32'($signed(lp[53:32]));
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### hdl/ppwi_pow10.sv
// Iterative power-of-ten unit: Q16.16 exponent in, saturated Q16.16 value out.
// Uses ppwi_pkg for log2(10) and the root factor table.
`default_nettype none
module ppwi_pow10 (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire signed [31:0]  y,
	output logic               done,
	output logic signed [31:0] result
);
	import ppwi_pkg::*;

	typedef enum logic [4:0] {
		P_IDLE  = 5'b00001,
		P_MUL   = 5'b00010,
		P_SPLIT = 5'b00100,
		P_ITER  = 5'b01000,
		P_SCALE = 5'b10000
	} pstate_t;

	pstate_t            st_q;
	logic signed [31:0] y_q;
	logic signed [63:0] tp_q;
	logic signed [35:0] t;
	logic signed [19:0] ip;
	logic signed [19:0] ip_q;
	logic [15:0]        f_q;
	logic [4:0]         k_q;
	logic [31:0]        r_q;
	logic [63:0]        rp;
	logic signed [20:0] s;
	logic [39:0]        rr;
	logic [39:0]        rs;
	logic [31:0]        scaled;

	always_comb begin
		// Exponent in base two, rounded to Q16.16.
		t  = 36'((tp_q + 64'sd134217728) >>> 28);
		ip = t[35:16];
		// One factor of the fraction product.
		rp = 64'({32'd0, r_q} * {32'd0, EXP_TAB[k_q]}) + 64'd536870912;
		// Final scaling by the integer part.
		s  = 21'sd14 - 21'(ip_q);
		rr = {8'd0, r_q};
		rs = rr;
		if (s > 21'sd0) begin
			rs = (rr + (40'd1 << (6'(s) - 6'd1))) >> 6'(s);
		end
		if (s >= 21'sd40) begin
			scaled = 32'd0;
		end else if (rs > 40'h7FFFFFFF) begin
			scaled = 32'h7FFFFFFF;
		end else begin
			scaled = rs[31:0];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= P_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				P_IDLE: begin
					if (start) begin
						st_q <= P_MUL;
					end
				end
				P_MUL: st_q <= P_SPLIT;
				P_SPLIT: begin
					if (ip >= 20'sd15) begin
						st_q <= P_IDLE;
						done <= 1'b1;
					end else begin
						st_q <= P_ITER;
					end
				end
				P_ITER: begin
					if (k_q == 5'd16) begin
						st_q <= P_SCALE;
					end
				end
				P_SCALE: begin
					st_q <= P_IDLE;
					done <= 1'b1;
				end
				default: st_q <= P_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (st_q)
			P_IDLE: y_q <= y;
			P_MUL: tp_q <= 64'(y_q * $signed({1'b0, LOG2_10_Q28}));
			P_SPLIT: begin
				ip_q   <= ip;
				f_q    <= t[15:0];
				k_q    <= 5'd1;
				r_q    <= 32'd1 << 30;
				result <= 32'h7FFFFFFF;
			end
			P_ITER: begin
				if (f_q[15]) begin
					r_q <= rp[61:30];
				end
				f_q <= {f_q[14:0], 1'b0};
				k_q <= k_q + 5'd1;
			end
			P_SCALE: result <= scaled;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### hdl/pilot_point_weighted_interpolation.sv
// Pilot point weighted interpolation: top level with the point store and row sequencer.
// A load item stays in S_IDLE; a valid row entry passes S_READ, S_MUL and S_ACC, and in
// log mode also S_LOG for the log10 unit (up to 30 normalize steps and 16 squarings).
// A row end passes S_FIN, plus S_POW in log mode for the power-of-ten unit.
// Async reset (arst_n) clears the state, fill count, accumulator, flags and log mode.
// Depends on ppwi_pkg, ppwi_if, ppwi_ram, ppwi_log10 and ppwi_pow10.
`default_nettype none
module pilot_point_weighted_interpolation #(
	parameter int MAX_POINTS = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	ppwi_in_if.sink     in_ch,
	ppwi_out_if.source  out_ch,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ppwi_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int WW = (CW > 11) ? CW : 11;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_READ = 7'b0000010,
		S_LOG  = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_ACC  = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_POW  = 7'b1000000
	} state_t;

	state_t             st_q;
	logic               out_pend_q;
	logic               log_mode_q;
	logic [30:0]        floor_q;
	logic [CW-1:0]      count_q;
	logic signed [63:0] acc_q;
	logic               bad_q;
	logic signed [31:0] weight_q;
	logic               last_q;
	logic signed [31:0] val_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] res_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic               out_error_q;

	logic               accept;
	logic               cfg_wr;
	logic [WW-1:0]      id_ext;
	logic [WW-1:0]      cnt_ext;
	logic [WW-1:0]      id_m1;
	logic               id_nz;
	logic               id_ok;
	logic               full;
	logic               mem_we;
	logic [31:0]        rdata;
	logic [30:0]        log_in;
	logic               log_start;
	logic               log_done;
	logic signed [31:0] log_res;
	logic               pow_start;
	logic               pow_done;
	logic signed [31:0] pow_res;
	logic signed [64:0] sum;
	logic signed [63:0] acc_next;
	logic signed [35:0] rq;
	logic signed [31:0] yq;
	logic               out_free;

	// Handshakes and lookup conditions.
	always_comb begin
		accept   = in_ch.valid && in_ch.ready;
		cfg_wr   = psel && penable && pwrite && pready;
		id_ext   = WW'(in_ch.point_id);
		cnt_ext  = WW'(count_q);
		id_m1    = id_ext - WW'(1);
		id_nz    = in_ch.point_id != 11'd0;
		id_ok    = id_nz && (id_ext <= cnt_ext);
		full     = count_q == CW'(MAX_POINTS);
		mem_we   = accept && (in_ch.func == FUNC_LOAD) && !full;
		out_free = !out_valid_q || out_ch.ready;
	end

	assign in_ch.ready   = (st_q == S_IDLE) && !out_pend_q;
	assign out_ch.valid  = out_valid_q;
	assign out_ch.row_value = out_value_q;
	assign out_ch.row_error = out_error_q;
	assign pready = 1'b1;

	// Point store.
	ppwi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_ch.point_value),
		.raddr (id_m1[AW-1:0]),
		.rdata (rdata)
	);

	// Log argument: the stored value if positive, else the floor register.
	always_comb begin
		log_in    = (!rdata[31] && rdata != 32'd0) ? rdata[30:0] : floor_q;
		log_start = (st_q == S_READ) && log_mode_q;
	end

	ppwi_log10 u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.v      (log_in),
		.done   (log_done),
		.result (log_res)
	);

	// Saturating accumulate and rounding to Q16.16.
	always_comb begin
		sum = {acc_q[63], acc_q} + {prod_q[63], prod_q};
		if (sum[64] != sum[63]) begin
			acc_next = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			acc_next = sum[63:0];
		end
		rq = ($signed({acc_q[63], acc_q[63:29]}) + 36'sd1) >>> 1;
		if (rq > 36'sd2147483647) begin
			yq = 32'h7FFFFFFF;
		end else if (rq < -36'sd2147483648) begin
			yq = 32'h80000000;
		end else begin
			yq = rq[31:0];
		end
		pow_start = (st_q == S_FIN) && log_mode_q;
	end

	ppwi_pow10 u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pow_start),
		.y      (yq),
		.done   (pow_done),
		.result (pow_res)
	);

	// Configuration registers and read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_mode_q <= 1'b0;
			floor_q    <= FLOOR_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2:2])
				REG_LOG_MODE:  log_mode_q <= pwdata[0];
				REG_LOG_FLOOR: floor_q    <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2:2])
			REG_LOG_MODE:  prdata = {31'd0, log_mode_q};
			REG_LOG_FLOOR: prdata = {1'b0, floor_q};
			default:       prdata = 32'd0;
		endcase
	end

	// Row sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			count_q     <= '0;
			acc_q       <= '0;
			bad_q       <= 1'b0;
			out_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A finished result waits here until the output register is free.
			if (out_pend_q && out_free) begin
				out_valid_q <= 1'b1;
				out_pend_q  <= 1'b0;
				acc_q       <= '0;
				bad_q       <= 1'b0;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						if (in_ch.func == FUNC_LOAD) begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
						end else if (id_ok) begin
							st_q <= S_READ;
						end else begin
							if (id_nz) begin
								bad_q <= 1'b1;
							end
							if (in_ch.last_in_row) begin
								st_q <= S_FIN;
							end
						end
					end
				end
				S_READ: st_q <= log_mode_q ? S_LOG : S_MUL;
				S_LOG: begin
					if (log_done) begin
						st_q <= S_MUL;
					end
				end
				S_MUL: st_q <= S_ACC;
				S_ACC: begin
					acc_q <= acc_next;
					st_q  <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (log_mode_q) begin
						st_q <= S_POW;
					end else begin
						st_q       <= S_IDLE;
						out_pend_q <= 1'b1;
					end
				end
				S_POW: begin
					if (pow_done) begin
						st_q       <= S_IDLE;
						out_pend_q <= 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			weight_q <= in_ch.weight;
			last_q   <= in_ch.last_in_row;
		end
		if (st_q == S_READ) begin
			val_q <= rdata;
		end else if (st_q == S_LOG && log_done) begin
			val_q <= log_res;
		end
		if (st_q == S_MUL) begin
			prod_q <= 64'(weight_q * val_q);
		end
		if (st_q == S_FIN) begin
			res_q <= yq;
		end else if (st_q == S_POW && pow_done) begin
			res_q <= pow_res;
		end
		if (out_pend_q && out_free) begin
			out_value_q <= res_q;
			out_error_q <= bad_q;
		end
	end
endmodule
`default_nettype wire

### dv/pilot_point_weighted_interpolation_test.sv
// Testbench for pilot point weighted interpolation: directed, log mode, fill, random rows.
// Results are checked against an in-bench predictor of the row arithmetic.
// Depends on ppwi_pkg, ppwi_if and the pilot_point_weighted_interpolation top level.
`default_nettype none
module pilot_point_weighted_interpolation_test;
	import ppwi_pkg::*;

	localparam int NPTS = 1024;

	typedef struct {
		logic               func;
		logic [10:0]        point_id;
		logic signed [31:0] point_value;
		logic signed [31:0] weight;
		logic               last_in_row;
		logic               known;
		logic signed [31:0] row_value;
		logic               row_error;
	} stim_row_t;

	typedef struct {
		logic signed [31:0] row_value;
		logic               row_error;
	} row_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ppwi_in_if in_ch();
	ppwi_out_if out_ch();

	pilot_point_weighted_interpolation dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state.
	logic [31:0] pred_store [0:NPTS-1];
	int unsigned pred_loaded;
	longint pred_acc;
	logic pred_bad;
	logic pred_log;
	logic [30:0] pred_floor;
	longint unsigned exp_root [0:16];

	row_result_t expected_rows[$];
	int errors;
	int rows_checked;
	int send_idle_pct, recv_idle_pct;

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint log10_q16(logic [31:0] v_in);
		logic [31:0] v;
		int n;
		longint unsigned m;
		longint frac, l2;
		v = v_in;
		if (v == 0) v = 1;
		v &= 32'h7FFF_FFFF;
		if (v == 0) v = 1;
		n = 30;
		while (n > 0 && v[n] == 1'b0) n--;
		m = longint'(v) << (30 - n);
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac |= 1;
				m >>= 1;
			end
		end
		l2 = longint'(n - 16) * 65536 + frac;
		return (l2 * longint'(LOG10_2_Q32) + 64'sd2147483648) >>> 32;
	endfunction

	function automatic longint pow10_q16(longint y);
		longint t, ip, s;
		longint unsigned f, r;
		t = (y * longint'(LOG2_10_Q28) + 64'sd134217728) >>> 28;
		ip = t >>> 16;
		f = t & 64'hFFFF;
		r = 64'd1 << 30;
		if (ip >= 15) return 64'h7FFF_FFFF;
		for (int k = 1; k <= 16; k++)
			if ((f >> (16 - k)) & 1) r = (r * exp_root[k] + (64'd1 << 29)) >> 30;
		s = 14 - ip;
		if (s > 0) begin
			if (s >= 40) return 0;
			r = (r + (64'd1 << (s - 1))) >> s;
		end
		if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
		return longint'(r);
	endfunction

	// Apply one accepted input item to the predictor; may queue a row result.
	task automatic predict_item(logic func, logic [10:0] id, logic signed [31:0] pv,
		logic signed [31:0] w, logic last);
		longint val, p, q;
		row_result_t res;
		if (func == FUNC_LOAD) begin
			if (pred_loaded < NPTS) begin
				pred_store[pred_loaded] = pv;
				pred_loaded++;
			end
			return;
		end
		if (id != 0) begin
			if (id > pred_loaded) begin
				pred_bad = 1'b1;
			end else begin
				val = longint'($signed(pred_store[id - 1]));
				if (pred_log) val = log10_q16(val > 0 ? val[31:0] : {1'b0, pred_floor});
				p = longint'(w) * val;
				if (p > 0 && pred_acc > 64'sh7FFF_FFFF_FFFF_FFFF - p)
					pred_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
				else if (p < 0 && pred_acc < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - p)
					pred_acc = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
				else
					pred_acc += p;
			end
		end
		if (!last) return;
		q = ((pred_acc >>> 29) + 1) >>> 1;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		if (pred_log) q = pow10_q16(q);
		res.row_value = q[31:0];
		res.row_error = pred_bad;
		expected_rows = {expected_rows, res};
		pred_acc = 0;
		pred_bad = 1'b0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#20_000_000;
		$display("pilot_point_weighted_interpolation test failed");
		$finish;
	end

	// Result receiver with random stalls; compares each transfer against the oldest expectation.
	initial begin
		row_result_t want;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (expected_rows.size() == 0) begin
					report_mismatch("unexpected result", out_ch.row_value, 0);
				end else begin
					want = expected_rows.pop_front();
					rows_checked++;
					if (out_ch.row_value !== want.row_value)
						report_mismatch("row_value", out_ch.row_value, want.row_value);
					if (out_ch.row_error !== want.row_error)
						report_mismatch("row_error", out_ch.row_error, want.row_error);
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Drive one input transfer; valid stays high from one transfer to the next
	// unless the sender idles or stops.
	task automatic send_item(logic func, logic [10:0] id, logic signed [31:0] pv,
		logic signed [31:0] w, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= func;
		in_ch.point_id <= id;
		in_ch.point_value <= pv;
		in_ch.weight <= w;
		in_ch.last_in_row <= last;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		predict_item(func, id, pv, w, last);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic apb_write(logic [0:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_LOG_MODE) pred_log = data[0];
		else pred_floor = data[30:0];
		@(posedge clk);
	endtask

	// Random well-formed rows, with some out-of-range ids, empty slots and load items mixed in.
	task automatic random_rows(int n_items);
		int sent, len;
		logic [10:0] id;
		logic signed [31:0] w;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(19) == 0) begin
				send_item(FUNC_LOAD, 11'($urandom), $urandom, $urandom, 1'($urandom));
				sent++;
				continue;
			end
			len = $urandom_range(1, 6);
			for (int j = 0; j < len; j++) begin
				case ($urandom_range(9))
					0: id = 0;
					1: id = 11'($urandom);
					default: id = 11'($urandom_range(1, pred_loaded));
				endcase
				case ($urandom_range(3))
					0: w = $urandom;
					default: w = $signed(32'($urandom_range(0, 32'h4000_0000))) >>> $urandom_range(4);
				endcase
				send_item(FUNC_ROW, id, $urandom, w, j == len - 1);
				sent++;
			end
		end
	endtask

	stim_row_t dir_table[$];

	task automatic table_add(stim_row_t r);
		dir_table = {dir_table, r};
	endtask

	function automatic stim_row_t mk(logic f, logic [10:0] id, logic [31:0] pv,
		logic [31:0] w, logic last, logic known, logic [31:0] rv, logic re);
		stim_row_t r;
		r = '{f, id, pv, w, last, known, rv, re};
		return r;
	endfunction

	// Stimulus.
	initial begin
		row_result_t want;
		errors = 0;
		rows_checked = 0;
		send_idle_pct = 32;
		recv_idle_pct = 46;
		pred_loaded = 0;
		pred_acc = 0;
		pred_bad = 1'b0;
		pred_log = 1'b0;
		pred_floor = FLOOR_RESET;
		exp_root[0] = 64'd1 << 31;
		for (int k = 1; k <= 16; k++) exp_root[k] = int_sqrt(exp_root[k - 1] << 30);
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.func = 1'b0; in_ch.point_id = '0;
		in_ch.point_value = '0; in_ch.weight = '0; in_ch.last_in_row = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty row after reset, bad id, loads of extreme values, extremes.
		table_add(mk(FUNC_ROW, 0, 0, 0, 1, 1, 0, 0));
		table_add(mk(FUNC_ROW, 1, 0, 32'h4000_0000, 1, 1, 0, 1));
		table_add(mk(FUNC_LOAD, 11'h7FF, 32'h0001_0000, 32'hFFFF_FFFF, 1, 0, 0, 0));
		table_add(mk(FUNC_LOAD, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
		table_add(mk(FUNC_LOAD, 0, 32'h8000_0000, 0, 0, 0, 0, 0));
		table_add(mk(FUNC_LOAD, 0, 32'h0000_0000, 0, 0, 0, 0, 0));
		table_add(mk(FUNC_LOAD, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		table_add(mk(FUNC_ROW, 1, 0, 32'h4000_0000, 1, 1, 32'h0001_0000, 0));
		table_add(mk(FUNC_ROW, 2, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
		table_add(mk(FUNC_ROW, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
		table_add(mk(FUNC_ROW, 2, 0, 32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF, 0));
		table_add(mk(FUNC_ROW, 3, 0, 32'h7FFF_FFFF, 1, 1, 32'h8000_0000, 0));
		table_add(mk(FUNC_ROW, 3, 0, 32'h8000_0000, 0, 0, 0, 0));
		table_add(mk(FUNC_ROW, 11'h7FF, 0, 32'h8000_0000, 1, 0, 0, 0));
		table_add(mk(FUNC_ROW, 4, 0, 32'h8000_0000, 0, 0, 0, 0));
		table_add(mk(FUNC_ROW, 5, 0, 32'h8000_0000, 1, 0, 0, 0));
		foreach (dir_table[i]) begin
			send_item(dir_table[i].func, dir_table[i].point_id, dir_table[i].point_value,
				dir_table[i].weight, dir_table[i].last_in_row);
			if (dir_table[i].known && expected_rows.size() != 0) begin
				want = expected_rows[$];
				if (want.row_value !== dir_table[i].row_value ||
					want.row_error !== dir_table[i].row_error)
					report_mismatch("directed table row", i, want.row_value);
			end
		end
		wait_drained();

		// Log mode with the reset floor, then extreme floors.
		apb_write(REG_LOG_MODE, 32'd1);
		foreach (dir_table[i])
			if (dir_table[i].func == FUNC_ROW)
				send_item(FUNC_ROW, dir_table[i].point_id, 0, dir_table[i].weight,
					dir_table[i].last_in_row);
		wait_drained();
		apb_write(REG_LOG_FLOOR, 32'd0);
		send_item(FUNC_ROW, 4, 0, 32'h4000_0000, 1);
		wait_drained();
		apb_write(REG_LOG_FLOOR, 32'hFFFF_FFFF);
		send_item(FUNC_ROW, 4, 0, 32'hC000_0000, 1);
		wait_drained();

		// Fill the store past its capacity with random values.
		apb_write(REG_LOG_MODE, 32'd0);
		while (pred_loaded < NPTS) send_item(FUNC_LOAD, 11'($urandom), $urandom, $urandom, 0);
		send_item(FUNC_LOAD, 0, 32'h1234_5678, 0, 0);
		send_item(FUNC_ROW, 11'd1024, 0, 32'h4000_0000, 0);
		send_item(FUNC_ROW, 11'd1025, 0, 32'h4000_0000, 1);

		// Random phases under each idling pattern and several register settings.
		send_idle_pct = 32; recv_idle_pct = 46;
		random_rows(160);
		wait_drained();
		apb_write(REG_LOG_MODE, 32'd1);
		apb_write(REG_LOG_FLOOR, $urandom_range(1, 32'h7FFF_FFFF));
		random_rows(160);
		wait_drained();
		send_idle_pct = 46; recv_idle_pct = 32;
		apb_write(REG_LOG_FLOOR, 32'd1);
		random_rows(160);
		wait_drained();
		apb_write(REG_LOG_MODE, 32'd0);
		random_rows(140);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_rows(160);
		wait_drained();
		apb_write(REG_LOG_MODE, 32'd1);
		apb_write(REG_LOG_FLOOR, 32'h7FFF_FFFF);
		random_rows(140);
		wait_drained();

		$display("Covered loads past capacity, linear and log rows, floor extremes and %0d rows.",
			rows_checked);
		if (errors == 0 && expected_rows.size() == 0) begin
			$display("pilot_point_weighted_interpolation test passed");
		end else begin
			$display("pilot_point_weighted_interpolation test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
